// ----- design/spfrc_pkg.sv -----
// shared types, constants and pixel conversion for the row scaler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spfrc_pkg;

    localparam int unsigned CFG_DATA_W  = 29;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned STEP_W      = 29;
    localparam int unsigned WIDTH_W     = 13;
    localparam int unsigned INDEX_W     = 13;
    localparam int unsigned POS_W       = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_X_STEP       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CONVERT_MODE = 2'd2;

    localparam logic [1:0] MODE_PASS      = 2'd0;
    localparam logic [1:0] MODE_4444_8888 = 2'd1;
    localparam logic [1:0] MODE_4444_PMUL = 2'd2;
    localparam logic [1:0] MODE_565_888   = 2'd3;

    localparam logic [12:0] PMUL_SCALE = 13'h1223;

    typedef struct packed {
        logic [31:0] src_pixel;
        logic        row_end;
    } src_beat_t;

    typedef struct packed {
        logic [31:0] dst_pixel;
        logic        run_last;
        logic        row_done;
    } dst_beat_t;

    typedef struct packed {
        logic accept;
        logic emit;
        logic finish;
    } spfrc_cmd_t;

    typedef struct packed {
        logic cond_now;
        logic next_cond;
        logic out_free;
    } spfrc_status_t;

    // colour nibble times alpha nibble, scaled to a byte
    function automatic logic [7:0] premul(input logic [3:0] c, input logic [3:0] a);
        logic [7:0]  ca;
        logic [20:0] p;
        ca = 8'(c) * 8'(a);
        p  = 21'(ca) * 21'(PMUL_SCALE);
        return p[19:12];
    endfunction

    function automatic logic [31:0] convert(input logic [31:0] pix, input logic [1:0] mode);
        logic [15:0] v;
        logic [31:0] w;
        logic [31:0] res;
        v = pix[15:0];
        w = {16'h0000, v};
        case (mode)
            MODE_4444_8888: res = {v[15:12], v[15:12], v[11:8], v[11:8],
                                   v[7:4], v[7:4], v[3:0], v[3:0]};
            MODE_4444_PMUL: res = {8'h00, premul(v[11:8], v[15:12]),
                                   premul(v[7:4], v[15:12]), premul(v[3:0], v[15:12])};
            MODE_565_888:   res = ((w & 32'h0000F800) << 8) | ((w & 32'h000007E0) << 5)
                                | ((w & 32'h0000E01F) << 3) | ((w & 32'h00000600) >> 1)
                                | ((w & 32'h0000001C) >> 2);
            default:        res = pix;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/spfrc_ctrl.sv -----
// controller state machine: sequences accept, emit run and row bookkeeping
// depends on spfrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module spfrc_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    src_valid,
    output logic                         src_ready,
    input  wire spfrc_pkg::spfrc_status_t status,
    output spfrc_pkg::spfrc_cmd_t        cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        src_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                src_ready = 1'b1;
                if (src_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.cond_now)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!status.next_cond)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/spfrc_datapath.sv -----
// datapath: config registers, source position, counters, conversion and output register
// depends on spfrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module spfrc_datapath #(
    parameter int unsigned MAX_ROW_WIDTH = 4096,
    parameter int unsigned MAX_REPEAT    = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire spfrc_pkg::src_beat_t                    src_data,
    input  wire logic                                    cfg_valid,
    input  wire logic [spfrc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [spfrc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                    dst_ready,
    output logic                                         dst_valid,
    output spfrc_pkg::dst_beat_t                         dst_data,
    input  wire spfrc_pkg::spfrc_cmd_t                   cmd,
    output spfrc_pkg::spfrc_status_t                     status
);

    localparam int unsigned N_W = $clog2(MAX_REPEAT + 1);
    localparam logic [N_W-1:0] N_MAX = N_W'(MAX_REPEAT);
    localparam logic [16:0] ROW_MAX = 17'(MAX_ROW_WIDTH);

    logic [spfrc_pkg::STEP_W-1:0]  x_step_reg;
    logic [spfrc_pkg::WIDTH_W-1:0] out_width_reg;
    logic [1:0]                    convert_mode_reg;

    logic [spfrc_pkg::POS_W-1:0]   pos_reg;
    logic [spfrc_pkg::INDEX_W-1:0] index_reg;
    logic [spfrc_pkg::WIDTH_W-1:0] emitted_reg;
    logic [N_W-1:0]                n_reg;
    logic                          row_end_reg;
    logic [31:0]                   conv_reg;
    logic                          out_valid_reg;
    spfrc_pkg::dst_beat_t          out_data_reg;

    logic [spfrc_pkg::WIDTH_W-1:0] width;
    logic [spfrc_pkg::POS_W-1:0]   pos_next;
    logic [spfrc_pkg::WIDTH_W:0]   emitted_inc;
    logic [N_W-1:0]                n_inc;
    logic                          row_end_now;
    logic                          next_cond;

    always_comb
    begin
        if ({4'b0000, out_width_reg} > ROW_MAX)
        begin
            width = ROW_MAX[spfrc_pkg::WIDTH_W-1:0];
        end
        else
        begin
            width = out_width_reg;
        end
    end

    assign pos_next    = pos_reg + {3'b000, x_step_reg};
    assign emitted_inc = {1'b0, emitted_reg} + 14'd1;
    assign n_inc       = n_reg + N_W'(1);
    assign next_cond   = (n_inc < N_MAX) && (emitted_inc < {1'b0, width})
                       && (pos_next[31:16] == {3'b000, index_reg});
    assign row_end_now = cmd.accept ? src_data.row_end : row_end_reg;

    assign status.cond_now  = (emitted_reg < width) && (pos_reg[31:16] == {3'b000, index_reg});
    assign status.next_cond = next_cond;
    assign status.out_free  = !out_valid_reg || dst_ready;

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_data_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_step_reg       <= 29'd65536;
            out_width_reg    <= 13'd1;
            convert_mode_reg <= spfrc_pkg::MODE_PASS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                spfrc_pkg::REG_X_STEP:       x_step_reg       <= cfg_data;
                spfrc_pkg::REG_OUT_WIDTH:    out_width_reg    <= cfg_data[spfrc_pkg::WIDTH_W-1:0];
                spfrc_pkg::REG_CONVERT_MODE: convert_mode_reg <= cfg_data[1:0];
                default:                     ;
            endcase
        end
    end

    // row state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            index_reg     <= '0;
            emitted_reg   <= '0;
            n_reg         <= '0;
            row_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                n_reg       <= '0;
                row_end_reg <= src_data.row_end;
            end
            else if (cmd.emit)
            begin
                n_reg <= n_inc;
            end
            if (cmd.finish && row_end_now)
            begin
                pos_reg     <= '0;
                index_reg   <= '0;
                emitted_reg <= '0;
            end
            else
            begin
                if (cmd.emit)
                begin
                    pos_reg     <= pos_next;
                    emitted_reg <= emitted_inc[spfrc_pkg::WIDTH_W-1:0];
                end
                if (cmd.finish)
                begin
                    index_reg <= index_reg + 13'd1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dst_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            conv_reg <= spfrc_pkg::convert(src_data.src_pixel, convert_mode_reg);
        end
        if (cmd.emit)
        begin
            out_data_reg.dst_pixel <= conv_reg;
            out_data_reg.run_last  <= !next_cond;
            out_data_reg.row_done  <= (emitted_inc == {1'b0, width});
        end
    end

endmodule

`default_nettype wire

// ----- design/scaled_pixel_format_row_converter.sv -----
// top level: nearest-neighbour row scaler with pixel format conversion
// depends on spfrc_pkg, spfrc_ctrl, spfrc_datapath
// a taken source pixel is converted into conv_reg; each result is then registered for output
// a source beat with k results holds off the next source beat until its last result is sent,
//   results leave one per cycle through a single output register unless dst_ready stalls it
// reset: rst_n asynchronous, clears position, index and count, config to defaults
`timescale 1ns / 1ps
`default_nettype none

module scaled_pixel_format_row_converter #(
    parameter int unsigned MAX_ROW_WIDTH = 4096,
    parameter int unsigned MAX_REPEAT    = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              src_valid,
    output logic                                   src_ready,
    input  wire spfrc_pkg::src_beat_t              src_data,
    output logic                                   dst_valid,
    input  wire logic                              dst_ready,
    output spfrc_pkg::dst_beat_t                   dst_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [spfrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [spfrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    spfrc_pkg::spfrc_cmd_t    cmd;
    spfrc_pkg::spfrc_status_t status;

    assign cfg_ready = 1'b1;

    spfrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .status    (status),
        .cmd       (cmd)
    );

    spfrc_datapath #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
        .MAX_REPEAT    (MAX_REPEAT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_data  (src_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dst_ready (dst_ready),
        .dst_valid (dst_valid),
        .dst_data  (dst_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
